[design/sbe_pkg.sv]
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared widths, opcodes, status and emit codes for the stack bytecode
// executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

	localparam int VALUE_W    = 32;
	localparam int DATA_DEPTH = 1024;
	localparam int DATA_AW    = $clog2(DATA_DEPTH);
	localparam int DEPTH_W    = $clog2(DATA_DEPTH + 1);
	localparam int CALL_DEPTH = 64;
	localparam int CALL_AW    = $clog2(CALL_DEPTH);
	localparam int RDEPTH_W   = $clog2(CALL_DEPTH + 1);
	localparam int VAR_COUNT  = 1024;
	localparam int VAR_AW     = $clog2(VAR_COUNT);
	localparam int LINE_W     = 16;
	localparam int CMD_W      = 8;
	localparam int IMM_W      = 32;
	localparam int VIDX_W     = 16;
	localparam int STATUS_W   = 4;
	localparam int KIND_W     = 3;

	typedef logic [VALUE_W-1:0] value_t;

	localparam logic [CMD_W-1:0] OP_PUSH   = 8'h00;
	localparam logic [CMD_W-1:0] OP_PUSHV  = 8'h01;
	localparam logic [CMD_W-1:0] OP_POPV   = 8'h02;
	localparam logic [CMD_W-1:0] OP_LOCK   = 8'h03;
	localparam logic [CMD_W-1:0] OP_INC    = 8'h04;
	localparam logic [CMD_W-1:0] OP_DEC    = 8'h05;
	localparam logic [CMD_W-1:0] OP_STR    = 8'h06;
	localparam logic [CMD_W-1:0] OP_REPEAT = 8'h07;
	localparam logic [CMD_W-1:0] OP_JUMP   = 8'h08;
	localparam logic [CMD_W-1:0] OP_CALL   = 8'h09;
	localparam logic [CMD_W-1:0] OP_RET    = 8'h0a;
	localparam logic [CMD_W-1:0] OP_JZ     = 8'h0b;
	localparam logic [CMD_W-1:0] OP_DELAY  = 8'h0c;
	localparam logic [CMD_W-1:0] OP_LOGV   = 8'h0d;
	localparam logic [CMD_W-1:0] OP_QUIT   = 8'h0e;
	localparam logic [CMD_W-1:0] OP_LOGC   = 8'h0f;
	localparam logic [CMD_W-1:0] OP_NEG    = 8'h10;
	localparam logic [CMD_W-1:0] OP_POW    = 8'h11;
	localparam logic [CMD_W-1:0] OP_MUL    = 8'h12;
	localparam logic [CMD_W-1:0] OP_DIV    = 8'h13;
	localparam logic [CMD_W-1:0] OP_MOD    = 8'h14;
	localparam logic [CMD_W-1:0] OP_ADD    = 8'h15;
	localparam logic [CMD_W-1:0] OP_SUB    = 8'h16;
	localparam logic [CMD_W-1:0] OP_EQ     = 8'h17;
	localparam logic [CMD_W-1:0] OP_NE     = 8'h18;
	localparam logic [CMD_W-1:0] OP_LE     = 8'h19;
	localparam logic [CMD_W-1:0] OP_GE     = 8'h1a;
	localparam logic [CMD_W-1:0] OP_LT     = 8'h1b;
	localparam logic [CMD_W-1:0] OP_GT     = 8'h1c;
	localparam logic [CMD_W-1:0] OP_NOT    = 8'h1d;
	localparam logic [CMD_W-1:0] OP_LAND   = 8'h1e;
	localparam logic [CMD_W-1:0] OP_LOR    = 8'h1f;
	localparam logic [CMD_W-1:0] OP_BAND   = 8'h20;
	localparam logic [CMD_W-1:0] OP_BOR    = 8'h21;
	localparam logic [CMD_W-1:0] OP_BXOR   = 8'h22;
	localparam logic [CMD_W-1:0] OP_BNOT   = 8'h23;
	localparam logic [CMD_W-1:0] OP_SHL    = 8'h24;
	localparam logic [CMD_W-1:0] OP_ASR    = 8'h25;
	localparam logic [CMD_W-1:0] OP_SQRT   = 8'h26;
	localparam logic [CMD_W-1:0] OP_CONST  = 8'h27;
	localparam logic [CMD_W-1:0] OP_KEY    = 8'h28;
	localparam logic [CMD_W-1:0] OP_DDEL   = 8'h29;
	localparam logic [CMD_W-1:0] OP_SDEL   = 8'h2a;
	localparam logic [CMD_W-1:0] OP_TYPED  = 8'h2b;
	localparam logic [CMD_W-1:0] OP_TYPES  = 8'h2c;
	localparam logic [CMD_W-1:0] OP_ADDC   = 8'h2d;
	localparam logic [CMD_W-1:0] OP_NL     = 8'h2e;
	localparam logic [CMD_W-1:0] OP_TEXT   = 8'h2f;
	localparam logic [CMD_W-1:0] OP_LINE   = 8'hff;

	localparam logic [STATUS_W-1:0] ST_OK     = 4'd0;
	localparam logic [STATUS_W-1:0] ST_SOVER  = 4'd1;
	localparam logic [STATUS_W-1:0] ST_SUNDER = 4'd2;
	localparam logic [STATUS_W-1:0] ST_VRANGE = 4'd3;
	localparam logic [STATUS_W-1:0] ST_CONST  = 4'd4;
	localparam logic [STATUS_W-1:0] ST_JRANGE = 4'd5;
	localparam logic [STATUS_W-1:0] ST_NEST   = 4'd6;
	localparam logic [STATUS_W-1:0] ST_COVER  = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CUNDER = 4'd8;
	localparam logic [STATUS_W-1:0] ST_BADOP  = 4'd9;
	localparam logic [STATUS_W-1:0] ST_DIVZ   = 4'd10;

	localparam logic [KIND_W-1:0] EK_NONE  = 3'd0;
	localparam logic [KIND_W-1:0] EK_LOGV  = 3'd1;
	localparam logic [KIND_W-1:0] EK_LOGC  = 3'd2;
	localparam logic [KIND_W-1:0] EK_DELAY = 3'd3;
	localparam logic [KIND_W-1:0] EK_KEY   = 3'd4;
	localparam logic [KIND_W-1:0] EK_TYPED = 3'd5;
	localparam logic [KIND_W-1:0] EK_DDEL  = 3'd6;
	localparam logic [KIND_W-1:0] EK_SDEL  = 3'd7;

	localparam logic [2:0] IT_MUL  = 3'd0;
	localparam logic [2:0] IT_POW  = 3'd1;
	localparam logic [2:0] IT_DIV  = 3'd2;
	localparam logic [2:0] IT_MOD  = 3'd3;
	localparam logic [2:0] IT_SQRT = 3'd4;

	typedef struct packed {
		logic       go;
		logic [2:0] op;
	} it_req_t;

endpackage

[design/sbe_req_if.sv]
// ----------------------------------------------------------------------------
// sbe_req_if
// Instruction channel: one decoded instruction per word.
// ----------------------------------------------------------------------------
interface sbe_req_if import sbe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [IMM_W-1:0]  imm;
	logic [VIDX_W-1:0]        var_index;

	modport source(output valid, cmd, imm, var_index, input ready);
	modport sink(input valid, cmd, imm, var_index, output ready);
endinterface

[design/sbe_rsp_if.sv]
// ----------------------------------------------------------------------------
// sbe_rsp_if
// Result channel: one result word per instruction.
// ----------------------------------------------------------------------------
interface sbe_rsp_if import sbe_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [LINE_W-1:0]         next_line;
	logic                      redirect;
	logic [KIND_W-1:0]         emit_kind;
	logic signed [IMM_W-1:0]   emit_value;
	logic                      halted;

	modport source(output valid, status, next_line, redirect, emit_kind, emit_value,
		halted, input ready);
	modport sink(input valid, status, next_line, redirect, emit_kind, emit_value,
		halted, output ready);
endinterface

[design/sbe_ram.sv]
// ----------------------------------------------------------------------------
// sbe_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sbe_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata <= mem[ra];
	end
endmodule

[design/sbe_iter.sv]
// ----------------------------------------------------------------------------
// sbe_iter
// Multi-cycle arithmetic unit: multiply, power, signed divide and modulo,
// and integer square root plus one.
// ----------------------------------------------------------------------------
module sbe_iter import sbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  it_req_t req,
	input  value_t  a,
	input  value_t  b,
	output logic    done,
	output value_t  result
);
	localparam logic [1:0] I_IDLE = 2'd0;
	localparam logic [1:0] I_RUN  = 2'd1;
	localparam logic [1:0] I_SIGN = 2'd2;
	localparam logic [1:0] I_DONE = 2'd3;
	localparam int CNT_W = $clog2(VALUE_W);

	logic [1:0]       ist_q;
	logic [2:0]       op_q;
	logic [CNT_W-1:0] cnt_q;
	value_t           rem_q, quo_q, den_q;
	logic             na_q, nb_q, ph_q;
	value_t           pr_q, base_q, exp_q;
	value_t           sx_q, sres_q, sbit_q;
	value_t           res_q;

	logic [VALUE_W:0]     trial, diff;
	value_t               mul_x, mul_y, snext;
	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W:0]     ssum;
	logic                 sfit;

	always_comb begin
		trial = {rem_q, quo_q[VALUE_W-1]};
		diff  = trial - {1'b0, den_q};
		mul_x = (op_q == IT_POW && !ph_q) ? pr_q : base_q;
		mul_y = (op_q == IT_MUL) ? exp_q : base_q;
		prod  = mul_x * mul_y;
		ssum  = {1'b0, sres_q} + {1'b0, sbit_q};
		sfit  = {1'b0, sx_q} >= ssum;
		snext = sfit ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ist_q <= I_IDLE;
		end else begin
			case (ist_q)
				I_IDLE: begin
					if (req.go) begin
						ist_q <= (req.op == IT_POW && b[VALUE_W-1]) ? I_DONE : I_RUN;
					end
				end
				I_RUN: begin
					case (op_q)
						IT_MUL: ist_q <= I_DONE;
						IT_POW: begin
							if (!ph_q && exp_q == '0) begin
								ist_q <= I_DONE;
							end
						end
						IT_SQRT: begin
							if (sbit_q[0]) begin
								ist_q <= I_DONE;
							end
						end
						default: begin
							if (cnt_q == CNT_W'(VALUE_W - 1)) begin
								ist_q <= I_SIGN;
							end
						end
					endcase
				end
				I_SIGN: ist_q <= I_DONE;
				default: ist_q <= I_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ist_q)
			I_IDLE: begin
				op_q   <= req.op;
				cnt_q  <= '0;
				na_q   <= a[VALUE_W-1];
				nb_q   <= b[VALUE_W-1];
				rem_q  <= '0;
				quo_q  <= a[VALUE_W-1] ? (~a + 1'b1) : a;
				den_q  <= b[VALUE_W-1] ? (~b + 1'b1) : b;
				pr_q   <= value_t'(1);
				base_q <= a;
				exp_q  <= b;
				ph_q   <= 1'b0;
				sx_q   <= a;
				sres_q <= '0;
				sbit_q <= value_t'(1) << (VALUE_W - 2);
				res_q  <= '0;
			end
			I_RUN: begin
				case (op_q)
					IT_MUL: res_q <= prod[VALUE_W-1:0];
					IT_POW: begin
						if (!ph_q) begin
							if (exp_q == '0) begin
								res_q <= pr_q;
							end else begin
								if (exp_q[0]) begin
									pr_q <= prod[VALUE_W-1:0];
								end
								ph_q <= 1'b1;
							end
						end else begin
							base_q <= prod[VALUE_W-1:0];
							exp_q  <= exp_q >> 1;
							ph_q   <= 1'b0;
						end
					end
					IT_SQRT: begin
						if (sfit) begin
							sx_q <= sx_q - ssum[VALUE_W-1:0];
						end
						sres_q <= snext;
						sbit_q <= sbit_q >> 2;
						res_q  <= snext + 1'b1;
					end
					default: begin
						if (!diff[VALUE_W]) begin
							rem_q <= diff[VALUE_W-1:0];
							quo_q <= {quo_q[VALUE_W-2:0], 1'b1};
						end else begin
							rem_q <= trial[VALUE_W-1:0];
							quo_q <= {quo_q[VALUE_W-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
					end
				endcase
			end
			I_SIGN: begin
				if (op_q == IT_MOD) begin
					res_q <= na_q ? (~rem_q + 1'b1) : rem_q;
				end else begin
					res_q <= (na_q ^ nb_q) ? (~quo_q + 1'b1) : quo_q;
				end
			end
			default: ;
		endcase
	end

	assign done   = (ist_q == I_DONE);
	assign result = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> ist_q == I_IDLE)
		else $error("iterative unit started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		ist_q == I_SIGN |-> op_q == IT_DIV || op_q == IT_MOD)
		else $error("sign fix-up on a non-division operation");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> ist_q == I_IDLE)
		else $error("done held for more than one cycle");
endmodule

[design/stack_bytecode_executor.sv]
// An accepted instruction passes the read, second read and execute states, and multiply,
// square root, divide, modulo and power then run in the arithmetic unit; the result word
// is registered once the output is free, and a new instruction is accepted only after that.
// The single read port of the data stack RAM reads the top and second in turn.
// After reset the variable RAM is cleared, one entry a cycle, through all 1024 entries;
// no instruction is accepted meanwhile, the line count register may be written.
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// Stack machine interpreter: data stack, call stack and variable file held in
// synchronous RAMs, read in turn, executed and written back per instruction.
// ----------------------------------------------------------------------------
module stack_bytecode_executor import sbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LINE_W-1:0] cfg_wdata,
	sbe_req_if.sink           req,
	sbe_rsp_if.source         rsp
);
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_RD2  = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_ITER = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]          state_q;
	logic [VAR_AW-1:0]   clr_q;
	logic [LINE_W-1:0]   lcount_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [RDEPTH_W-1:0] rdepth_q;
	logic [LINE_W-1:0]   line_q, tgt_q;
	value_t              rem_q;
	logic                stop_q;
	logic [CMD_W-1:0]    cmd_q;
	value_t              imm_q;
	logic [VIDX_W-1:0]   vi_q;
	value_t              b_q;
	logic [DATA_AW-1:0]  ds_wa_q;
	logic [STATUS_W-1:0] res_st_q;
	logic [LINE_W-1:0]   res_line_q;
	logic                res_redir_q, res_halt_q;
	logic [KIND_W-1:0]   res_kind_q;
	value_t              res_ev_q;
	logic                ov_q;

	value_t              ds_rdata, a, var_val, it_res, alu;
	logic [VALUE_W:0]    var_rdata;
	logic [LINE_W-1:0]   rt_rdata;
	logic                var_lock, it_done, vok, exec_ok, load_ok, clearing;
	logic [STATUS_W-1:0] st;
	logic [KIND_W-1:0]   kind;
	logic                redir, stop_n, ds_we_w, var_we_w, rt_we_w;
	logic [LINE_W-1:0]   line_n, tgt_n;
	value_t              rem_n, rem_m1, ds_wd_w;
	logic [DEPTH_W-1:0]  depth_n, dm1, dm2;
	logic [RDEPTH_W-1:0] rdepth_n;
	logic [DATA_AW-1:0]  ds_wa_w;
	logic [VALUE_W:0]    var_wd_w;
	logic [VAR_AW-1:0]   var_a;
	it_req_t             it_req;
	logic                ds_we, var_we;
	logic [DATA_AW-1:0]  ds_wa, ds_ra;
	value_t              ds_wd;
	logic [VAR_AW-1:0]   var_wa;
	logic [VALUE_W:0]    var_wd;
	logic [RDEPTH_W-1:0] rdm1;

	function automatic logic tgt_ok(input value_t t, input logic [LINE_W-1:0] lc);
		return !t[VALUE_W-1] && t != '0 && t <= value_t'(lc);
	endfunction

	assign a        = ds_rdata;
	assign var_val  = var_rdata[VALUE_W-1:0];
	assign var_lock = var_rdata[VALUE_W];
	assign vok      = 32'(vi_q) < VAR_COUNT;
	assign dm1      = depth_q - 1'b1;
	assign dm2      = depth_q - 2'd2;
	assign rdm1     = rdepth_q - 1'b1;
	assign rem_m1   = rem_q - 1'b1;
	assign var_a    = (cmd_q == OP_LINE) ? '0 : vi_q[VAR_AW-1:0];
	assign clearing = (state_q == S_CLR);

	always_comb begin
		case (cmd_q)
			OP_ADD:  alu = a + b_q;
			OP_SUB:  alu = a - b_q;
			OP_EQ:   alu = value_t'(a == b_q);
			OP_NE:   alu = value_t'(a != b_q);
			OP_LE:   alu = value_t'(!($signed(b_q) < $signed(a)));
			OP_GE:   alu = value_t'(!($signed(a) < $signed(b_q)));
			OP_LT:   alu = value_t'($signed(a) < $signed(b_q));
			OP_GT:   alu = value_t'($signed(b_q) < $signed(a));
			OP_LAND: alu = value_t'(a != '0 && b_q != '0);
			OP_LOR:  alu = value_t'(a != '0 || b_q != '0);
			OP_BAND: alu = a & b_q;
			OP_BOR:  alu = a | b_q;
			OP_BXOR: alu = a ^ b_q;
			OP_SHL:  alu = (b_q >= value_t'(VALUE_W)) ? '0
				: (a << b_q[$clog2(VALUE_W)-1:0]);
			default: alu = (b_q >= value_t'(VALUE_W)) ? {VALUE_W{a[VALUE_W-1]}}
				: value_t'($signed(a) >>> b_q[$clog2(VALUE_W)-1:0]);
		endcase
	end

	always_comb begin
		st       = ST_OK;
		kind     = EK_NONE;
		redir    = 1'b0;
		line_n   = line_q;
		tgt_n    = tgt_q;
		rem_n    = rem_q;
		depth_n  = depth_q;
		rdepth_n = rdepth_q;
		stop_n   = 1'b0;
		ds_we_w  = 1'b0;
		ds_wa_w  = dm1[DATA_AW-1:0];
		ds_wd_w  = imm_q;
		var_we_w = 1'b0;
		var_wd_w = var_rdata;
		rt_we_w  = 1'b0;
		it_req   = '{go: 1'b0, op: IT_MUL};
		case (cmd_q)
			OP_PUSH, OP_PUSHV: begin
				if (depth_q >= DEPTH_W'(DATA_DEPTH)) begin
					st = ST_SOVER;
				end else if (cmd_q == OP_PUSHV && !vok) begin
					st = ST_VRANGE;
				end else begin
					ds_we_w = 1'b1;
					ds_wa_w = depth_q[DATA_AW-1:0];
					ds_wd_w = (cmd_q == OP_PUSH) ? imm_q : var_val;
					depth_n = depth_q + 1'b1;
				end
			end
			OP_POPV: begin
				if (depth_q == '0) begin
					st = ST_SUNDER;
				end else if (!vok) begin
					st = ST_VRANGE;
				end else if (var_lock) begin
					st = ST_CONST;
				end else begin
					var_we_w = 1'b1;
					var_wd_w = {1'b0, b_q};
					depth_n  = dm1;
				end
			end
			OP_LOCK: begin
				var_we_w = vok;
				var_wd_w = {1'b1, var_val};
			end
			OP_INC, OP_DEC: begin
				var_we_w = vok;
				var_wd_w = {var_lock, (cmd_q == OP_INC) ? (var_val + 1'b1) : (var_val - 1'b1)};
			end
			OP_STR, OP_TYPES, OP_ADDC, OP_NL, OP_TEXT: ;
			OP_REPEAT: begin
				if (rem_q != '0 && !rem_q[VALUE_W-1]) begin
					if ({1'b0, tgt_q} + 1'b1 != {1'b0, line_q}) begin
						st = ST_NEST;
					end else if (rem_m1 != '0 && !tgt_ok(value_t'(tgt_q), lcount_q)) begin
						st = ST_JRANGE;
					end else begin
						rem_n = rem_m1;
						if (rem_m1 != '0) begin
							line_n = tgt_q;
							redir  = 1'b1;
						end
					end
				end else if (depth_q < DEPTH_W'(2)) begin
					st = ST_SUNDER;
				end else if (!tgt_ok(b_q, lcount_q)) begin
					st = ST_JRANGE;
				end else begin
					tgt_n   = b_q[LINE_W-1:0];
					rem_n   = a - 1'b1;
					depth_n = dm2;
					line_n  = b_q[LINE_W-1:0];
					redir   = 1'b1;
				end
			end
			OP_JUMP, OP_CALL: begin
				if (cmd_q == OP_CALL && rdepth_q >= RDEPTH_W'(CALL_DEPTH)) begin
					st = ST_COVER;
				end else if (depth_q == '0) begin
					st = ST_SUNDER;
				end else if (!tgt_ok(b_q, lcount_q)) begin
					st = ST_JRANGE;
				end else begin
					if (cmd_q == OP_CALL) begin
						rt_we_w  = 1'b1;
						rdepth_n = rdepth_q + 1'b1;
					end
					depth_n = dm1;
					line_n  = b_q[LINE_W-1:0];
					redir   = 1'b1;
				end
			end
			OP_RET: begin
				if (rdepth_q == '0) begin
					st = ST_CUNDER;
				end else if (!tgt_ok(value_t'(rt_rdata), lcount_q)) begin
					st = ST_JRANGE;
				end else begin
					rdepth_n = rdm1;
					line_n   = rt_rdata;
					redir    = 1'b1;
				end
			end
			OP_JZ: begin
				if (depth_q < DEPTH_W'(2)) begin
					st = ST_SUNDER;
				end else if (a == '0 && !tgt_ok(b_q, lcount_q)) begin
					st = ST_JRANGE;
				end else begin
					depth_n = dm2;
					if (a == '0) begin
						line_n = b_q[LINE_W-1:0];
						redir  = 1'b1;
					end
				end
			end
			OP_DELAY, OP_LOGV, OP_LOGC, OP_KEY, OP_DDEL, OP_SDEL, OP_TYPED: begin
				if (depth_q == '0) begin
					st = ST_SUNDER;
				end else begin
					case (cmd_q)
						OP_DELAY: kind = EK_DELAY;
						OP_LOGV:  kind = EK_LOGV;
						OP_LOGC:  kind = EK_LOGC;
						OP_KEY:   kind = EK_KEY;
						OP_DDEL:  kind = EK_DDEL;
						OP_SDEL:  kind = EK_SDEL;
						default:  kind = EK_TYPED;
					endcase
					depth_n = dm1;
				end
			end
			OP_QUIT: stop_n = 1'b1;
			OP_NEG, OP_NOT, OP_BNOT, OP_SQRT: begin
				if (depth_q == '0) begin
					st = ST_SUNDER;
				end else if (cmd_q == OP_SQRT) begin
					it_req = '{go: 1'b1, op: IT_SQRT};
				end else begin
					ds_we_w = 1'b1;
					ds_wd_w = (cmd_q == OP_NEG) ? (~b_q + 1'b1)
						: (cmd_q == OP_NOT) ? value_t'(b_q == '0) : ~b_q;
				end
			end
			OP_CONST: begin
				var_we_w = vok;
				var_wd_w = {1'b1, imm_q};
			end
			OP_LINE: begin
				line_n   = line_q + 1'b1;
				var_we_w = 1'b1;
				var_wd_w = {var_lock, value_t'(line_n)};
			end
			default: begin
				if (cmd_q >= OP_POW && cmd_q <= OP_ASR) begin
					ds_wa_w = dm2[DATA_AW-1:0];
					if (depth_q < DEPTH_W'(2)) begin
						st = ST_SUNDER;
					end else if ((cmd_q == OP_DIV || cmd_q == OP_MOD) && b_q == '0) begin
						st = ST_DIVZ;
					end else begin
						depth_n = dm1;
						case (cmd_q)
							OP_POW: it_req = '{go: 1'b1, op: IT_POW};
							OP_MUL: it_req = '{go: 1'b1, op: IT_MUL};
							OP_DIV: it_req = '{go: 1'b1, op: IT_DIV};
							OP_MOD: it_req = '{go: 1'b1, op: IT_MOD};
							default: begin
								ds_we_w = 1'b1;
								ds_wd_w = alu;
							end
						endcase
					end
				end else begin
					st = ST_BADOP;
				end
			end
		endcase
	end

	assign exec_ok = (state_q == S_EXEC) && !stop_q && st == ST_OK;
	assign load_ok = !ov_q || rsp.ready;

	assign ds_ra  = (state_q == S_RD2) ? dm2[DATA_AW-1:0] : dm1[DATA_AW-1:0];
	assign ds_we  = (exec_ok && ds_we_w) || (state_q == S_ITER && it_done);
	assign ds_wa  = (state_q == S_ITER) ? ds_wa_q : ds_wa_w;
	assign ds_wd  = (state_q == S_ITER) ? it_res : ds_wd_w;
	assign var_we = clearing || (exec_ok && var_we_w);
	assign var_wa = clearing ? clr_q : var_a;
	assign var_wd = clearing ? '0 : var_wd_w;

	sbe_ram #(.DEPTH(DATA_DEPTH), .WIDTH(VALUE_W)) u_dstack (
		.clk(clk), .we(ds_we), .wa(ds_wa), .wd(ds_wd), .ra(ds_ra), .rdata(ds_rdata)
	);

	sbe_ram #(.DEPTH(VAR_COUNT), .WIDTH(VALUE_W + 1)) u_vars (
		.clk(clk), .we(var_we), .wa(var_wa), .wd(var_wd), .ra(var_a), .rdata(var_rdata)
	);

	sbe_ram #(.DEPTH(CALL_DEPTH), .WIDTH(LINE_W)) u_rstack (
		.clk(clk), .we(exec_ok && rt_we_w), .wa(rdepth_q[CALL_AW-1:0]),
		.wd(line_q + 1'b1), .ra(rdm1[CALL_AW-1:0]), .rdata(rt_rdata)
	);

	sbe_iter u_iter (
		.clk(clk), .arst_n(arst_n), .req(exec_ok ? it_req : '0),
		.a((cmd_q == OP_SQRT) ? b_q : a), .b(b_q), .done(it_done), .result(it_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			lcount_q <= '0;
			depth_q  <= '0;
			rdepth_q <= '0;
			line_q   <= '0;
			tgt_q    <= '0;
			rem_q    <= '0;
			stop_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				lcount_q <= cfg_wdata;
			end
			if (rsp.valid && rsp.ready && !(state_q == S_FIN && load_ok)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VAR_AW'(VAR_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_RD2;
				S_RD2: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= (exec_ok && it_req.go) ? S_ITER : S_FIN;
					if (!stop_q) begin
						stop_q <= stop_n || st != ST_OK;
					end
					if (exec_ok) begin
						depth_q  <= depth_n;
						rdepth_q <= rdepth_n;
						line_q   <= line_n;
						tgt_q    <= tgt_n;
						rem_q    <= rem_n;
					end
				end
				S_ITER: begin
					if (it_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_ok) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			cmd_q <= req.cmd;
			imm_q <= req.imm;
			vi_q  <= req.var_index;
		end
		if (state_q == S_RD2) begin
			b_q <= ds_rdata;
		end
		if (state_q == S_EXEC) begin
			ds_wa_q     <= ds_wa_w;
			res_halt_q  <= stop_q || stop_n || st != ST_OK;
			res_line_q  <= exec_ok ? line_n : line_q;
			res_st_q    <= stop_q ? ST_OK : st;
			res_redir_q <= exec_ok && redir;
			res_kind_q  <= exec_ok ? kind : EK_NONE;
			res_ev_q    <= (exec_ok && kind != EK_NONE) ? b_q : '0;
		end
		if (state_q == S_FIN && load_ok) begin
			rsp.status     <= res_st_q;
			rsp.next_line  <= res_line_q;
			rsp.redirect   <= res_redir_q;
			rsp.emit_kind  <= res_kind_q;
			rsp.emit_value <= res_ev_q;
			rsp.halted     <= res_halt_q;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(DATA_DEPTH))
		else $error("data stack depth beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		rdepth_q <= RDEPTH_W'(CALL_DEPTH))
		else $error("call stack depth beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("halted block resumed without reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_RD)
		else $error("accepted word did not start execution");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ITER && it_done |-> ds_we)
		else $error("arithmetic result not written back");
endmodule
